// ===== rtl/lbgm_pkg.sv =====
// Package for the LED bar graph meter: request and result types, color codes,
// controller states and the command and status groups between the modules.
// No dependencies.
`timescale 1ns / 1ps

package lbgm_pkg;

  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;
  localparam int FILL_W = 16;
  localparam int DIV_W  = 14;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [FILL_W-1:0] FILL_UNIT = 16'd250;
  localparam logic [6:0] PERCENT_SCALE = 7'd100;
  localparam logic [7:0] SPEED_SCALE_RESET = 8'd100;
  localparam logic [7:0] FULL_BRIGHT_RESET = 8'd250;
  localparam logic [7:0] THIRD_RECIP = 8'd171;

  typedef enum logic [2:0] {
    COL_BLUE    = 3'd0,
    COL_RED     = 3'd1,
    COL_GREEN   = 3'd2,
    COL_YELLOW  = 3'd3,
    COL_MAGENTA = 3'd4,
    COL_WHITE   = 3'd5,
    COL_CYAN    = 3'd6,
    COL_DEFAULT = 3'd7
  } lbgm_color_t;

  typedef enum logic {
    CFG_SPEED_SCALE = 1'b0,
    CFG_FULL_BRIGHT = 1'b1
  } lbgm_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_FILL,
    S_FIRST,
    S_SEND
  } lbgm_state_t;

  typedef struct packed {
    logic              func;
    logic [2:0]        color;
    logic [7:0]        percent;
    logic signed [7:0] speed;
    logic [4:0]        start_led;
    logic [4:0]        finish_led;
  } lbgm_in_t;

  typedef struct packed {
    logic [4:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } lbgm_out_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic calc_fill;
    logic load_led;
  } lbgm_cmd_t;

  typedef struct packed {
    logic speed_mode;
    logic div_done;
    logic last;
  } lbgm_status_t;

endpackage

// ===== rtl/lbgm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the speed percent.
// Depends on lbgm_pkg.
`timescale 1ns / 1ps

module lbgm_div import lbgm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [7:0]       divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [7:0]           rem;
  logic [7:0]           dsr;
  logic [DIV_W-1:0]     quo;
  logic [8:0]           trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W);
      done <= 1'b0;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != DIV_CNT_W'(1);
      done <= cnt == DIV_CNT_W'(1);
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? 8'(trial - {1'b0, dsr}) : trial[7:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider reports done while still busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy && !done)
    else $error("divider did not start");

endmodule

// ===== rtl/lbgm_dp.sv =====
// Datapath of the LED bar graph meter: configuration registers, request
// registers, fill computation, LED walk and color mapping. Uses lbgm_div and lbgm_pkg.
`timescale 1ns / 1ps

module lbgm_dp import lbgm_pkg::*; #(
  parameter int LED_COUNT = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  lbgm_in_t     in_data,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data,
  input  lbgm_cmd_t    cmd,
  output lbgm_status_t status,
  output lbgm_out_t    out_data
);

  localparam int LastLed = LED_COUNT - 1;

  logic [7:0] speed_scale;
  logic [7:0] full_bright;

  logic [IDX_W-1:0]  start_sat;
  logic [IDX_W-1:0]  finish_sat;
  logic              up_in;
  logic [IDX_W-1:0]  span;
  logic [8:0]        mag_in;
  lbgm_color_t       color_in;

  logic              speed_mode;
  lbgm_color_t       color;
  logic [7:0]        percent;
  logic [8:0]        mag;
  logic              up;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  rem;
  logic [FILL_W-1:0] fill;

  logic [DIV_W-1:0]  quotient;
  logic [DIV_W-1:0]  dividend;
  logic              div_done;
  logic [7:0]        pct_eff;
  logic [13:0]       prod;
  logic [16:0]       times5;

  logic              full;
  logic [7:0]        bright;
  logic [7:0]        half;
  logic [15:0]       third_prod;
  logic [7:0]        third;
  lbgm_out_t         led_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale <= SPEED_SCALE_RESET;
      full_bright <= FULL_BRIGHT_RESET;
    end else if (cfg_we) begin
      unique case (lbgm_cfg_t'(cfg_index))
        CFG_SPEED_SCALE: speed_scale <= cfg_data;
        CFG_FULL_BRIGHT: full_bright <= cfg_data;
        default:         speed_scale <= speed_scale;
      endcase
    end
  end

  always_comb begin
    start_sat  = (int'(in_data.start_led) > LastLed) ? IDX_W'(LastLed) : in_data.start_led;
    finish_sat = (int'(in_data.finish_led) > LastLed) ? IDX_W'(LastLed) : in_data.finish_led;
    up_in      = finish_sat > start_sat;
    span       = up_in ? (finish_sat - start_sat) : (start_sat - finish_sat);
    if (in_data.speed == 8'sd0) begin
      color_in = COL_WHITE;
      mag_in   = '0;
    end else if (in_data.speed[7]) begin
      color_in = COL_BLUE;
      mag_in   = 9'd256 - {1'b0, in_data.speed};
    end else begin
      color_in = COL_GREEN;
      mag_in   = {1'b0, in_data.speed};
    end
    if (!in_data.func) begin
      color_in = lbgm_color_t'(in_data.color);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      speed_mode <= in_data.func;
      color      <= color_in;
      percent    <= in_data.percent;
      mag        <= mag_in;
      up         <= up_in;
      idx        <= start_sat;
      n          <= {1'b0, span} + CNT_W'(1);
    end else if (cmd.load_led) begin
      idx <= up ? idx + 1'b1 : idx - 1'b1;
    end
  end

  assign dividend = DIV_W'(mag) * DIV_W'(PERCENT_SCALE);

  lbgm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (speed_scale),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    if (!speed_mode) begin
      pct_eff = percent;
    end else if (speed_scale == 8'd0) begin
      pct_eff = '0;
    end else if (|quotient[DIV_W-1:8]) begin
      pct_eff = 8'hFF;
    end else begin
      pct_eff = quotient[7:0];
    end
    prod   = 14'(n) * 14'(pct_eff);
    times5 = {1'b0, prod, 2'b00} + {3'b000, prod};
  end

  always_comb begin
    full       = fill > FILL_UNIT;
    bright     = full ? full_bright : fill[7:0];
    half       = {1'b0, bright[7:1]};
    third_prod = 16'(bright) * 16'(THIRD_RECIP);
    third      = {1'b0, third_prod[15:9]};
    led_next.led_index = idx;
    led_next.last      = rem == CNT_W'(1);
    led_next.red       = '0;
    led_next.green     = '0;
    led_next.blue      = '0;
    unique case (color)
      COL_BLUE:    led_next.blue  = bright;
      COL_RED:     led_next.red   = bright;
      COL_GREEN:   led_next.green = bright;
      COL_YELLOW: begin
        led_next.red   = half;
        led_next.green = half;
      end
      COL_MAGENTA: begin
        led_next.red  = half;
        led_next.blue = half;
      end
      COL_CYAN: begin
        led_next.green = half;
        led_next.blue  = half;
      end
      default: begin
        led_next.red   = third;
        led_next.green = third;
        led_next.blue  = third;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_fill) begin
      fill <= times5[16:1];
      rem  <= n;
    end else if (cmd.load_led) begin
      fill     <= full ? fill - FILL_UNIT : '0;
      rem      <= rem - 1'b1;
      out_data <= led_next;
    end
  end

  assign status.speed_mode = speed_mode;
  assign status.div_done   = div_done;
  assign status.last       = out_data.last;

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_led |-> rem != '0)
    else $error("LED walk stepped past the end of the run");

endmodule

// ===== rtl/lbgm_ctrl.sv =====
// Controller state machine of the LED bar graph meter: sequences request
// load, speed division, fill computation and the per-LED result walk. Uses lbgm_pkg.
`timescale 1ns / 1ps

module lbgm_ctrl import lbgm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  lbgm_status_t status,
  output lbgm_cmd_t    cmd
);

  lbgm_state_t state;
  lbgm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_START;
      S_START: state_next = status.speed_mode ? S_DIV : S_FILL;
      S_DIV:   if (status.div_done) state_next = S_FILL;
      S_FILL:  state_next = S_FIRST;
      S_FIRST: state_next = S_SEND;
      S_SEND:  if (out_ready && status.last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_START: cmd.div_start = status.speed_mode;
      S_DIV:   cmd = '0;
      S_FILL:  cmd.calc_fill = 1'b1;
      S_FIRST: cmd.load_led = 1'b1;
      S_SEND: begin
        out_valid    = 1'b1;
        cmd.load_led = out_ready && !status.last;
      end
      default: cmd = '0;
    endcase
  end

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("second request taken while one is in progress");
  a_first_led: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIRST)
    else $error("result shown before the first LED was loaded");

endmodule

// ===== rtl/led_bar_graph_meter_unit.sv =====
// LED bar graph meter: one request lights a run of N LEDs, one RGB result per LED.
// Level mode: after the request is taken the controller passes S_START, S_FILL and S_FIRST
// before out_valid rises; speed mode adds S_DIV for the 14-step serial divider. Then one
// result per cycle while out_ready is high.
// One request at a time; the serial LED walk and the divider set the rate.
// Synchronous reset sets speed_scale to 100, full_bright to 250, and the controller idle.
`timescale 1ns / 1ps

module led_bar_graph_meter_unit import lbgm_pkg::*; #(
  parameter int LED_COUNT = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lbgm_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output lbgm_out_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  lbgm_cmd_t    cmd;
  lbgm_status_t status;

  lbgm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lbgm_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== sim/led_bar_graph_meter_unit_tb.sv =====
// Self-checking testbench for led_bar_graph_meter_unit: directed and random bar requests,
// checked result by result against an in-bench predictor of the LED walk and fill.
// Depends on lbgm_pkg and the led_bar_graph_meter_unit RTL.
`timescale 1ns / 1ps

module led_bar_graph_meter_unit_tb;
  import lbgm_pkg::*;

  localparam int NUM_LEDS    = 24;
  localparam int FILL_STEP   = 250;
  localparam int CYCLE_LIMIT = 400_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  lbgm_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  lbgm_out_t   out_data;
  logic        cfg_we = 1'b0;
  lbgm_cfg_t   cfg_index = CFG_SPEED_SCALE;
  logic [7:0]  cfg_data = '0;

  logic [7:0]  model_speed_scale = SPEED_SCALE_RESET;
  logic [7:0]  model_full_bright = FULL_BRIGHT_RESET;
  lbgm_out_t   led_expect_q[$];
  int          err_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  int          ready_hold = 0;

  led_bar_graph_meter_unit #(.LED_COUNT(NUM_LEDS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic lbgm_in_t req_of(logic f, logic [2:0] col, logic [7:0] pct,
                                      logic [7:0] spd, logic [4:0] first, logic [4:0] lastled);
    lbgm_in_t r;
    r.func       = f;
    r.color      = col;
    r.percent    = pct;
    r.speed      = spd;
    r.start_led  = first;
    r.finish_led = lastled;
    return r;
  endfunction

  // Expected LED results of one bar request, in walking order.
  task automatic predict_bar(lbgm_in_t req);
    int unsigned first, lastled, mag, pct, n, fill, idx;
    logic [7:0]  sraw, b, h, t;
    lbgm_color_t col;
    bit          up;
    lbgm_out_t   o;
    first   = (int'(req.start_led) > NUM_LEDS - 1) ? NUM_LEDS - 1 : int'(req.start_led);
    lastled = (int'(req.finish_led) > NUM_LEDS - 1) ? NUM_LEDS - 1 : int'(req.finish_led);
    col = lbgm_color_t'(req.color);
    pct = int'(req.percent);
    if (req.func) begin
      sraw = req.speed;
      if (sraw == 8'd0) begin
        col = COL_WHITE;
        mag = 0;
      end else if (sraw[7]) begin
        col = COL_BLUE;
        mag = 256 - int'(sraw);
      end else begin
        col = COL_GREEN;
        mag = int'(sraw);
      end
      if (model_speed_scale == 8'd0) begin
        pct = 0;
      end else begin
        pct = (mag * 100) / int'(model_speed_scale);
        if (pct > 255) pct = 255;
      end
    end
    up   = lastled > first;
    n    = (up ? lastled - first : first - lastled) + 1;
    fill = (n * FILL_STEP * pct) / 100;
    idx  = first;
    for (int k = 0; k < n; k++) begin
      if (fill > FILL_STEP) begin
        b = model_full_bright;
        fill -= FILL_STEP;
      end else if (fill > 0) begin
        b = fill[7:0];
        fill = 0;
      end else begin
        b = 8'd0;
      end
      h = b / 8'd2;
      t = b / 8'd3;
      o = '0;
      o.led_index = idx[4:0];
      case (col)
        COL_BLUE: begin
          o.blue = b;
        end
        COL_RED: begin
          o.red = b;
        end
        COL_GREEN: begin
          o.green = b;
        end
        COL_YELLOW: begin
          o.red = h;
          o.green = h;
        end
        COL_MAGENTA: begin
          o.red = h;
          o.blue = h;
        end
        COL_CYAN: begin
          o.green = h;
          o.blue = h;
        end
        default: begin
          o.red = t;
          o.green = t;
          o.blue = t;
        end
      endcase
      o.last = (k + 1 == n);
      led_expect_q.push_back(o);
      if (up) idx++; else idx--;
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    lbgm_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (led_expect_q.size() == 0) begin
          $error("unexpected LED result: led_index %0d", out_data.led_index);
          err_count++;
        end else begin
          want = led_expect_q.pop_front();
          check_field("led_index", int'(want.led_index), int'(out_data.led_index));
          check_field("red", int'(want.red), int'(out_data.red));
          check_field("green", int'(want.green), int'(out_data.green));
          check_field("blue", int'(want.blue), int'(out_data.blue));
          check_field("last", int'(want.last), int'(out_data.last));
        end
      end
      if (quiet) begin
        out_ready  <= 1'b1;
        ready_hold = 0;
      end else if (ready_hold > 0) begin
        ready_hold--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready  <= 1'b0;
        ready_hold = $urandom_range(0, 18);
      end else begin
        out_ready  <= 1'b1;
        ready_hold = $urandom_range(0, 10);
      end
    end
  end

  // Presents one request, possibly after a gap, and returns at the edge that takes it.
  task automatic send_request(lbgm_in_t req);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_bar(req);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (led_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(lbgm_cfg_t idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SPEED_SCALE) model_speed_scale = val;
    else model_full_bright = val;
    @(posedge clk);
  endtask

  task automatic test_level_mode();
    send_request(req_of(1'b0, COL_BLUE, 8'd0, 8'h00, 5'd0, 5'd23));
    send_request(req_of(1'b0, COL_RED, 8'd100, 8'hFF, 5'd0, 5'd23));
    send_request(req_of(1'b0, COL_GREEN, 8'd255, 8'h80, 5'd23, 5'd0));
    send_request(req_of(1'b0, COL_YELLOW, 8'd50, 8'h7F, 5'd5, 5'd5));
    send_request(req_of(1'b0, COL_MAGENTA, 8'd37, 8'h01, 5'd31, 5'd20));
    send_request(req_of(1'b0, COL_WHITE, 8'd99, 8'h55, 5'd10, 5'd31));
    send_request(req_of(1'b0, COL_CYAN, 8'd1, 8'hAA, 5'd3, 5'd0));
    send_request(req_of(1'b0, COL_DEFAULT, 8'd73, 8'h00, 5'd24, 5'd25));
    wait_drain();
  endtask

  task automatic test_speed_mode();
    send_request(req_of(1'b1, COL_RED, 8'd200, 8'h00, 5'd0, 5'd9));
    send_request(req_of(1'b1, COL_CYAN, 8'd0, 8'h7F, 5'd0, 5'd23));
    send_request(req_of(1'b1, COL_YELLOW, 8'd255, 8'h80, 5'd23, 5'd0));
    send_request(req_of(1'b1, COL_BLUE, 8'd17, 8'h01, 5'd2, 5'd6));
    send_request(req_of(1'b1, COL_MAGENTA, 8'd88, 8'hFF, 5'd6, 5'd2));
    send_request(req_of(1'b1, COL_WHITE, 8'd5, 8'h32, 5'd12, 5'd19));
    wait_drain();
  endtask

  task automatic test_config_extremes();
    write_cfg(CFG_SPEED_SCALE, 8'd0);
    send_request(req_of(1'b1, COL_RED, 8'd100, 8'h7F, 5'd0, 5'd7));
    send_request(req_of(1'b1, COL_RED, 8'd100, 8'h80, 5'd7, 5'd0));
    wait_drain();
    write_cfg(CFG_SPEED_SCALE, 8'd1);
    write_cfg(CFG_FULL_BRIGHT, 8'd0);
    send_request(req_of(1'b1, COL_GREEN, 8'd0, 8'h03, 5'd0, 5'd23));
    send_request(req_of(1'b0, COL_RED, 8'd60, 8'h00, 5'd4, 5'd15));
    wait_drain();
    write_cfg(CFG_SPEED_SCALE, 8'd255);
    write_cfg(CFG_FULL_BRIGHT, 8'd255);
    send_request(req_of(1'b1, COL_BLUE, 8'd0, 8'h81, 5'd20, 5'd3));
    send_request(req_of(1'b0, COL_DEFAULT, 8'd80, 8'h00, 5'd0, 5'd23));
    wait_drain();
  endtask

  task automatic test_random_requests();
    lbgm_in_t req;
    for (int phase = 0; phase < 4; phase++) begin
      case ($urandom_range(0, 3))
        0: write_cfg(CFG_SPEED_SCALE, 8'd0);
        1: write_cfg(CFG_SPEED_SCALE, 8'd255);
        default: write_cfg(CFG_SPEED_SCALE, 8'($urandom_range(1, 254)));
      endcase
      write_cfg(CFG_FULL_BRIGHT, 8'($urandom_range(0, 255)));
      quiet = (phase == 3);
      for (int i = 0; i < 28; i++) begin
        req.func  = 1'($urandom_range(0, 1));
        req.color = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
          0: req.percent = 8'($urandom_range(0, 110));
          1: req.percent = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd100;
          default: req.percent = 8'($urandom_range(0, 255));
        endcase
        req.speed      = 8'($urandom_range(0, 255));
        req.start_led  = 5'($urandom_range(0, 31));
        req.finish_led = ($urandom_range(0, 7) == 0) ? req.start_led : 5'($urandom_range(0, 31));
        send_request(req);
      end
      wait_drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_level_mode();
    test_speed_mode();
    test_config_extremes();
    test_random_requests();
    wait_drain();
    repeat (40) @(posedge clk);
    if (err_count == 0 && led_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lbgm_pkg.sv
rtl/lbgm_div.sv
rtl/lbgm_dp.sv
rtl/lbgm_ctrl.sv
rtl/led_bar_graph_meter_unit.sv
sim/led_bar_graph_meter_unit_tb.sv
